[rtl/sge_pkg.sv]
`timescale 1ns / 1ps
package sge_pkg;
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam int POS_W = 7;
endpackage

[rtl/sge_if.sv]
`timescale 1ns / 1ps
interface sge_in_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sample_value;
  logic                          end_of_sequence;
  modport source (output valid, sample_value, end_of_sequence, input ready);
  modport sink (input valid, sample_value, end_of_sequence, output ready);
endinterface

interface sge_out_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic [6:0]                    position;
  logic signed [VALUE_WIDTH-1:0] second_greater;
  logic [1:0]                    status;
  logic                          last_of_run;
  modport source (output valid, position, second_greater, status, last_of_run, input ready);
  modport sink (input valid, position, second_greater, status, last_of_run, output ready);
endinterface

[rtl/sge_front.sv]
`timescale 1ns / 1ps
// front: takes beats and queues them for the stack engine
module sge_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  sge_in_if.sink                 in_ch,
  output logic                   q_valid,
  input  logic                   q_pop,
  output logic [VALUE_WIDTH:0]   q_data
);
  logic [VALUE_WIDTH:0] mem [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;

  assign in_ch.ready = (count != 2'd2);
  assign q_valid     = (count != 2'd0);
  assign q_data      = mem[rd_ptr];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mem[wr_ptr] <= {in_ch.end_of_sequence, in_ch.sample_value};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'((in_ch.valid && in_ch.ready) ? 1 : 0) - 2'(q_pop ? 1 : 0);
    end
  end
endmodule

[rtl/sge_back.sv]
`timescale 1ns / 1ps
// back: runs the two monotonic stacks, every memory read is registered
module sge_back #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic [VALUE_WIDTH:0] q_data,
  sge_out_if.source            out_ch
);
  import sge_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int HW = AW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P2A  = 4'd1;
  localparam logic [3:0] S_P2V  = 4'd2;
  localparam logic [3:0] S_P2C  = 4'd3;
  localparam logic [3:0] S_S1A  = 4'd4;
  localparam logic [3:0] S_S1V  = 4'd5;
  localparam logic [3:0] S_S1C  = 4'd6;
  localparam logic [3:0] S_MVA  = 4'd7;
  localparam logic [3:0] S_MVW  = 4'd8;
  localparam logic [3:0] S_PUSH = 4'd9;
  localparam logic [3:0] S_F2A  = 4'd10;
  localparam logic [3:0] S_F2E  = 4'd11;
  localparam logic [3:0] S_F1A  = 4'd12;
  localparam logic [3:0] S_F1E  = 4'd13;
  localparam logic [3:0] S_OVF  = 4'd14;

  logic [VALUE_WIDTH-1:0] vstore [DEPTH];
  logic [AW-1:0]          stk1 [DEPTH];
  logic [AW-1:0]          stk2 [DEPTH];
  logic [HW-1:0]          h1, h2, run_base, mv;
  logic [HW-1:0]          next_pos, emitted;
  logic [3:0]             state;
  logic [VALUE_WIDTH-1:0] v;
  logic                   last;
  logic                   ovf;
  logic                   p_valid;
  logic [AW-1:0]          p_pos;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [AW-1:0]          s1_q, s2_q;
  logic [AW-1:0]          s1_addr, s2_addr, rd_addr;

  logic                   o_valid;
  logic [POS_W-1:0]       o_pos;
  logic [VALUE_WIDTH-1:0] o_val;
  logic [1:0]             o_st;
  logic                   o_last;

  logic                   o_free;
  logic                   smaller;
  logic                   more;
  logic                   no_ovf_beat;
  logic                   beat_go;

  assign o_free      = !o_valid || out_ch.ready;
  assign smaller     = $signed(rd_val) < $signed(v);
  assign more        = (h2 != '0) && smaller;
  assign no_ovf_beat = !ovf || (emitted >= HW'(DEPTH - 1));
  assign q_pop       = (state == S_IDLE) && q_valid;

  assign out_ch.valid          = o_valid;
  assign out_ch.position       = o_pos;
  assign out_ch.second_greater = o_val;
  assign out_ch.status         = o_st;
  assign out_ch.last_of_run    = o_last;

  // read addresses, held steady while a state waits on the output
  assign s2_addr = AW'(h2 - HW'(1));
  assign rd_addr = (state == S_P2A || state == S_P2V || state == S_P2C) ? s2_q : s1_q;

  always_comb begin
    case (state)
      S_MVA:        s1_addr = AW'(mv);
      S_F1A, S_F1E: s1_addr = AW'(h1 - HW'(1));
      default:      s1_addr = AW'(run_base - HW'(1));
    endcase
  end

  // registered reads of the stacks and the value store
  always_ff @(posedge clk) begin
    s1_q   <= stk1[s1_addr];
    s2_q   <= stk2[s2_addr];
    rd_val <= vstore[rd_addr];
  end

  // a result beat is loaded in these states once the output is free
  assign beat_go = o_free && ((state == S_P2C && p_valid) || state == S_F2E ||
                              state == S_F1E || state == S_OVF);

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (beat_go) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  // sequencer: address, value read and compare are separate states
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      h1 <= '0; h2 <= '0; next_pos <= '0;
      run_base <= '0; mv <= '0; emitted <= '0;
      p_valid <= 1'b0; ovf <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            v       <= q_data[VALUE_WIDTH-1:0];
            last    <= q_data[VALUE_WIDTH];
            emitted <= '0;
            p_valid <= 1'b0;
            if (next_pos >= HW'(DEPTH)) begin
              ovf   <= 1'b1;
              state <= q_data[VALUE_WIDTH] ? S_F2A : S_OVF;
            end else begin
              ovf      <= 1'b0;
              vstore[AW'(next_pos)] <= q_data[VALUE_WIDTH-1:0];
              run_base <= h1;
              if (h2 != '0) begin
                state <= S_P2A;
              end else if (h1 != '0) begin
                state <= S_S1A;
              end else begin
                state <= S_PUSH;
              end
            end
          end
        end
        S_P2A: begin
          state <= S_P2V;
        end
        S_P2V: begin
          state <= S_P2C;
        end
        S_P2C: begin
          // a popped entry is held until we know whether another follows
          if (!p_valid || o_free) begin
            if (p_valid) begin
              o_pos   <= POS_W'(p_pos); o_val <= v;
              o_st    <= ST_FOUND;
              o_last  <= !more && !last;
              emitted <= emitted + HW'(1);
            end
            if (more) begin
              p_valid <= 1'b1;
              p_pos   <= s2_q;
              h2      <= h2 - HW'(1);
              state   <= (h2 == HW'(1)) ? S_P2C : S_P2A;
            end else begin
              p_valid <= 1'b0;
              state   <= (run_base != '0) ? S_S1A : S_PUSH;
            end
          end
        end
        S_S1A: begin
          state <= S_S1V;
        end
        S_S1V: begin
          state <= S_S1C;
        end
        S_S1C: begin
          // walk down the smaller run at the top of stack one
          if (smaller) begin
            run_base <= run_base - HW'(1);
            if (run_base == HW'(1)) begin
              mv <= '0; state <= S_MVA;
            end else begin
              state <= S_S1A;
            end
          end else begin
            mv <= run_base; state <= S_MVA;
          end
        end
        S_MVA: begin
          state <= (mv < h1) ? S_MVW : S_PUSH;
        end
        S_MVW: begin
          stk2[AW'(h2)] <= s1_q;
          h2    <= h2 + HW'(1);
          mv    <= mv + HW'(1);
          state <= S_MVA;
        end
        S_PUSH: begin
          stk1[AW'(run_base)] <= AW'(next_pos);
          h1       <= run_base + HW'(1);
          next_pos <= next_pos + HW'(1);
          state    <= last ? S_F2A : S_IDLE;
        end
        S_F2A: begin
          state <= (h2 != '0) ? S_F2E : S_F1A;
        end
        S_F2E: begin
          if (o_free) begin
            o_pos   <= POS_W'(s2_q);
            o_val   <= '0; o_st <= ST_NONE;
            o_last  <= (h2 == HW'(1)) && (h1 == '0) && no_ovf_beat;
            emitted <= emitted + HW'(1);
            h2      <= h2 - HW'(1);
            state   <= S_F2A;
          end
        end
        S_F1A: begin
          if (h1 != '0) begin
            state <= S_F1E;
          end else if (ovf && emitted < HW'(DEPTH)) begin
            state <= S_OVF;
          end else begin
            next_pos <= '0; state <= S_IDLE;
          end
        end
        S_F1E: begin
          if (o_free) begin
            o_pos   <= POS_W'(s1_q);
            o_val   <= '0; o_st <= ST_NONE;
            o_last  <= (h1 == HW'(1)) && no_ovf_beat;
            emitted <= emitted + HW'(1);
            h1      <= h1 - HW'(1);
            state   <= S_F1A;
          end
        end
        S_OVF: begin
          if (o_free) begin
            o_pos <= POS_W'(DEPTH); o_val <= '0;
            o_st  <= ST_OVERFLOW; o_last <= 1'b1;
            if (last) next_pos <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/second_greater_element_stream.sv]
`timescale 1ns / 1ps
// Second greater element stream.
// in_ch: one signed sample per beat, end_of_sequence marks the final sample.
// out_ch: result beats (position, second_greater, status, last_of_run) in
// discovery order; status 0 found, 1 none (flush), 2 overflow drop.
// A two-entry queue decouples input from the stack engine, so input is
// taken while the engine works or the output waits.
// All stack and value reads are registered: a sample starts in the idle
// state, each stack entry compared passes address, value read and compare
// states, each moved entry passes address and write states, and then the
// sample is pushed. Each flush beat passes an address and an emit state.
// A stalled receiver holds the output register and stalls the engine
// when it has a beat to load; the input queue fills after two beats
// and then drops in_ch.ready.
// Reset (rst, synchronous) empties the queue and both stacks and starts
// a new sequence at position 0. Samples beyond DEPTH per sequence are
// answered with one overflow beat.
module second_greater_element_stream #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  sge_in_if.sink     in_ch,
  sge_out_if.source  out_ch
);
  logic                 q_valid;
  logic                 q_pop;
  logic [VALUE_WIDTH:0] q_data;

  sge_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  sge_back #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop),
    .q_data(q_data), .out_ch(out_ch)
  );
endmodule

[tb/sge_tb_if.sv]
`timescale 1ns / 1ps
// no extra interfaces needed: the channel interfaces come from the rtl
// this file holds the small shared record type for expected beats
package sge_tb_pkg;
  typedef struct packed {
    logic [6:0]         position;
    logic signed [31:0] second_greater;
    logic [1:0]         status;
    logic               last_of_run;
  } sge_result_t;
endpackage

[tb/tb_second_greater_element_stream.sv]
`timescale 1ns / 1ps
module tb_second_greater_element_stream;
  import sge_pkg::*;
  import sge_tb_pkg::*;

  localparam int DEPTH = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sge_in_if  #(.VALUE_WIDTH(32)) in_ch ();
  sge_out_if #(.VALUE_WIDTH(32)) out_ch ();

  second_greater_element_stream #(.DEPTH(DEPTH), .VALUE_WIDTH(32)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] seen_values [DEPTH];
  int                 first_stack [DEPTH];
  int                 second_stack [DEPTH];
  int                 first_height;
  int                 second_height;
  int                 seq_position;

  sge_result_t expected_results [$];
  int          error_count;
  int          items_sent;
  int          results_seen;
  int          overflow_seen;
  int          found_seen;
  bit          calm_mode;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic void push_result(inout sge_result_t run[$], input int pos,
                                      input logic signed [31:0] val, input logic [1:0] st);
    sge_result_t r;
    r.position       = pos[6:0];
    r.second_greater = (st == ST_FOUND) ? val : '0;
    r.status         = st;
    r.last_of_run    = 1'b0;
    run.insert(run.size(), r);
  endfunction

  function automatic void flush_waiting(inout sge_result_t run[$]);
    while (second_height > 0) begin
      second_height--;
      push_result(run, second_stack[second_height], '0, ST_NONE);
    end
    while (first_height > 0) begin
      first_height--;
      push_result(run, first_stack[first_height], '0, ST_NONE);
    end
    seq_position = 0;
  endfunction

  // compute the beats one sample produces and queue them
  function automatic void predict_second_greater(input logic signed [31:0] val, input bit last);
    sge_result_t run[$];
    int base;
    if (seq_position >= DEPTH) begin
      if (last) begin
        flush_waiting(run);
        if (run.size() < DEPTH) push_result(run, DEPTH, '0, ST_OVERFLOW);
      end else begin
        push_result(run, DEPTH, '0, ST_OVERFLOW);
      end
    end else begin
      seen_values[seq_position] = val;
      while (second_height > 0 && seen_values[second_stack[second_height-1]] < val) begin
        second_height--;
        push_result(run, second_stack[second_height], val, ST_FOUND);
      end
      base = first_height;
      while (base > 0 && seen_values[first_stack[base-1]] < val) base--;
      for (int k = base; k < first_height; k++) begin
        if (second_height < DEPTH) begin
          second_stack[second_height] = first_stack[k];
          second_height++;
        end
      end
      first_height = base;
      if (first_height < DEPTH) begin
        first_stack[first_height] = seq_position;
        first_height++;
      end
      seq_position++;
      if (last) flush_waiting(run);
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) expected_results.insert(expected_results.size(), run[i]);
  endfunction

  // send one beat, with an optional random gap first
  task automatic send_sample(input logic signed [31:0] val, input bit last);
    int gap;
    if (!calm_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.sample_value    <= val;
    in_ch.end_of_sequence <= last;
    predict_second_greater(val, last);
    items_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver stalls
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm_mode && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 5);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    sge_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.status == ST_OVERFLOW) overflow_seen++;
      if (out_ch.status == ST_FOUND) found_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat pos %0d", out_ch.position));
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.position !== exp_r.position)
          report_mismatch($sformatf("position %0d, want %0d", out_ch.position, exp_r.position));
        if (out_ch.second_greater !== exp_r.second_greater)
          report_mismatch($sformatf("pos %0d second_greater %0d, want %0d", exp_r.position,
                                    out_ch.second_greater, exp_r.second_greater));
        if (out_ch.status !== exp_r.status)
          report_mismatch($sformatf("pos %0d status %0d, want %0d", exp_r.position,
                                    out_ch.status, exp_r.status));
        if (out_ch.last_of_run !== exp_r.last_of_run)
          report_mismatch($sformatf("pos %0d last_of_run %0b, want %0b", exp_r.position,
                                    out_ch.last_of_run, exp_r.last_of_run));
      end
    end
  end

  // extremes, equal values, flush order and a one-item sequence
  task automatic test_directed();
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd5, 1'b0);
    send_sample(32'sd3, 1'b0);
    send_sample(32'sd9, 1'b0);
    send_sample(32'sd2, 1'b1);
    send_sample(32'sd7, 1'b1);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sd4, 1'b0);
    send_sample(32'sd4, 1'b0);
    send_sample(32'sd8, 1'b0);
    send_sample(32'sh5555_5555, 1'b0);
    send_sample(32'shAAAA_AAAA, 1'b1);
  endtask

  // fill past depth with a falling run, then end the sequence on a full flush
  task automatic test_overflow();
    for (int i = 0; i < DEPTH + 3; i++)
      send_sample($signed(32'(DEPTH - i)), i == DEPTH + 2);
    // random values fill past depth, giving overflow beats before the sequence ends
    for (int i = 0; i < DEPTH + 2; i++) send_sample($signed(32'($urandom)), 1'b0);
    send_sample(32'sd0, 1'b1);
  endtask

  // hold the sender until all results are back
  task automatic test_drain_pause();
    wait_drained();
    send_sample(32'sd11, 1'b1);
  endtask

  // random sequences, mostly short with narrow values to hit ties
  task automatic test_random(input int count);
    int len;
    int sent;
    logic signed [31:0] v;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        v = ($urandom_range(0, 1) == 0) ? $signed(32'($urandom_range(0, 15)) - 32'sd8)
                                        : $signed(32'($urandom));
        send_sample(v, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.sample_value    <= '0;
    in_ch.end_of_sequence <= 1'b0;
    calm_mode     = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    results_seen  = 0;
    overflow_seen = 0;
    found_seen    = 0;
    first_height  = 0;
    second_height = 0;
    seq_position  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_drain_pause();
    test_random(80);
    calm_mode = 1'b1;
    test_random(30);
    wait_drained();
    $display("sent %0d samples, checked %0d beats (%0d found, %0d overflow)",
             items_sent, results_seen, found_seen, overflow_seen);
    if (error_count == 0) begin
      $display("second_greater_element_stream regression: pass");
    end else begin
      $display("second_greater_element_stream regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("second_greater_element_stream regression: fail");
    $finish;
  end
endmodule
